// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// prop must hold at every rising clock edge outside reset
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expr must never be true outside reset
`define BSE_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSE_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- hw/rtl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the bubble sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int DEPTH_DEFAULT = 64;  // element store entries
	localparam int QDEPTH        = 4;   // input queue entries, power of two
	localparam int VW            = 32;  // element width

	typedef struct packed {
		logic signed [VW-1:0] value;
		logic                 last_in;
	} src_item_t;

	typedef struct packed {
		logic signed [VW-1:0] sorted_value;
		logic                 last_out;
		logic                 overflow;
	} res_item_t;

	// phase of the back end, seen by the top level
	typedef struct packed {
		logic loading;
		logic sorting;
		logic emitting;
	} stat_t;

endpackage

// ----- hw/rtl/bubble_sort_engine_unit.sv -----
// ----------------------------------------------------------------------------
// bubble_sort_engine_unit
// Collects a set of signed 32-bit elements, bubble sorts it, streams it out.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | transfer when
//  --------+--------------------------------+----------------------------
//  source  | src_valid, src_stall, src_item | src_valid && !src_stall
//  result  | res_valid, res_stall, res_item | res_valid && !res_stall
//
//  Loading takes one element per cycle; a four-entry queue keeps accepting
//  while the back end sorts or emits, then raises src_stall.
//  A set of n elements sorts in at most n-1 passes; a pass over m elements
//  issues m reads, makes the last compare once the registered read data
//  returns and then writes back the carried element. A pass with no swap
//  ends the sort.
//  Results follow one per cycle while res_stall is low; each is read from
//  the RAM into registered read data, then moved into the output register.
//  Reset clears all control state; the element RAM is not cleared.
//  res_stall holds the output register; element reads wait behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bubble_sort_engine_unit #(
	parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  bse_pkg::src_item_t src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output bse_pkg::res_item_t res_item
);
	import bse_pkg::*;

	logic      q_valid;
	logic      q_pop;
	src_item_t q_item;
	stat_t     st;

	// front: input queue
	bse_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (src_valid),
		.stall   (src_stall),
		.item    (src_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	// back: store, sort passes and output streaming
	bse_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.st        (st)
	);

	// a new result only appears after an emit cycle
	`BSE_ASSERT(a_res_from_emit, clk, arst_n, $rose(res_valid) |-> $past(st.emitting), "result outside emit phase")
	// the queue is drained only while a set is loading
	`BSE_NEVER(a_pop_in_load, clk, arst_n, q_pop && !st.loading, "queue pop outside load phase")
	// leaving the emit phase leaves the final element in the output register
	`BSE_ASSERT(a_emit_ends_last, clk, arst_n, $fell(st.emitting) |-> (res_valid && res_item.last_out), "emit ended without last")
	// the back end is always in exactly one phase
	`BSE_NEVER(a_one_phase, clk, arst_n, $countones(st) != 1, "phase flags not one-hot")

endmodule

// ----- hw/rtl/bse_ram.sv -----
// ----------------------------------------------------------------------------
// bse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/bse_front.sv -----
// ----------------------------------------------------------------------------
// bse_front
// Input side: takes element transfers into a short queue for the back end.
// ----------------------------------------------------------------------------
module bse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  bse_pkg::src_item_t item,
	output logic              q_valid,
	input  logic              q_pop,
	output bse_pkg::src_item_t q_item
);
	import bse_pkg::*;

	localparam int QW = $clog2(QDEPTH);

	src_item_t     q_mem_q [QDEPTH];
	logic [QW-1:0] head_q;
	logic [QW-1:0] tail_q;
	logic [QW:0]   fill_q;
	logic          push;

	assign stall   = (fill_q == (QW+1)'(QDEPTH));
	assign push    = valid && !stall;
	assign q_valid = (fill_q != '0);
	assign q_item  = q_mem_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[tail_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (q_pop) begin
				head_q <= head_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/bse_back.sv -----
// ----------------------------------------------------------------------------
// bse_back
// Execution side: stores a set, sorts it in place by bubble passes over the
// element RAM, then streams it out through an output register.
// ----------------------------------------------------------------------------
module bse_back #(
	parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  bse_pkg::src_item_t q_item,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output bse_pkg::res_item_t res_item,
	output bse_pkg::stat_t     st
);
	import bse_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_PEND = 2'd2;  // write back carry at pass end
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] lim_q;       // elements covered by the current pass
	logic [CW-1:0] rd_idx_q;
	logic          rd_v_s1;
	logic [CW-1:0] idx_s1;
	logic [VW-1:0] carry_q;     // largest element seen so far in this pass
	logic          moved_q;
	logic [CW-1:0] out_idx_q;
	logic          pend_q;      // RAM read data holds an element not yet sent
	logic [CW-1:0] pend_idx_q;
	logic          res_v_q;
	res_item_t     res_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [VW-1:0] wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [VW-1:0] rdata;

	logic          full;
	logic [CW-1:0] cnt_nx;
	logic          sort_issue;
	logic          last_arr;
	logic          swap;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] lim_m1;
	logic          move;
	logic          emit_issue;
	logic          pend_last;

	bse_ram #(.W(VW), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign full       = (cnt_q == CW'(DEPTH));
	assign cnt_nx     = full ? cnt_q : cnt_q + 1'b1;
	assign q_pop      = (state_q == ST_LOAD) && q_valid;
	assign sort_issue = (state_q == ST_SORT) && (rd_idx_q < lim_q);
	assign idx_m1     = idx_s1 - 1'b1;
	assign lim_m1     = lim_q - 1'b1;
	assign last_arr   = rd_v_s1 && (idx_s1 == lim_m1);
	assign swap       = $signed(carry_q) > $signed(rdata);
	assign move       = pend_q && (!res_v_q || !res_stall);
	assign emit_issue = (state_q == ST_EMIT) && (out_idx_q < cnt_q) && (!pend_q || move);
	assign pend_last  = (pend_idx_q == cnt_q - 1'b1);

	// RAM port steering
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				we    = q_pop && !full;
				waddr = cnt_q[AW-1:0];
				wdata = q_item.value;
			end
			ST_SORT: begin
				re    = sort_issue;
				raddr = rd_idx_q[AW-1:0];
				we    = rd_v_s1 && (idx_s1 != '0);
				waddr = idx_m1[AW-1:0];
				wdata = swap ? rdata : carry_q;
			end
			ST_PEND: begin
				we    = 1'b1;
				waddr = lim_m1[AW-1:0];
				wdata = carry_q;
			end
			ST_EMIT: begin
				re    = emit_issue;
				raddr = out_idx_q[AW-1:0];
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (rd_v_s1 && (idx_s1 == '0 || !swap)) begin
			carry_q <= rdata;
		end
		if (emit_issue) begin
			pend_idx_q <= out_idx_q;
		end
		if (move) begin
			res_q.sorted_value <= $signed(rdata);
			res_q.last_out     <= pend_last;
			res_q.overflow     <= ovf_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			lim_q     <= '0;
			rd_idx_q  <= '0;
			rd_v_s1   <= 1'b0;
			moved_q   <= 1'b0;
			out_idx_q <= '0;
			pend_q    <= 1'b0;
			res_v_q   <= 1'b0;
		end else begin
			rd_v_s1 <= sort_issue;
			if (move) begin
				res_v_q <= 1'b1;
			end else if (!res_stall) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						cnt_q <= cnt_nx;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (q_item.last_in) begin
							lim_q     <= cnt_nx;
							rd_idx_q  <= '0;
							moved_q   <= 1'b0;
							out_idx_q <= '0;
							state_q   <= (cnt_nx > CW'(1)) ? ST_SORT : ST_EMIT;
						end
					end
				end
				ST_SORT: begin
					if (sort_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rd_v_s1 && (idx_s1 != '0) && swap) begin
						moved_q <= 1'b1;
					end
					if (last_arr) begin
						state_q <= ST_PEND;
					end
				end
				ST_PEND: begin
					if (!moved_q || (lim_q == CW'(2))) begin
						state_q <= ST_EMIT;
					end else begin
						lim_q    <= lim_m1;
						rd_idx_q <= '0;
						moved_q  <= 1'b0;
						state_q  <= ST_SORT;
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						out_idx_q <= out_idx_q + 1'b1;
						pend_q    <= 1'b1;
					end else if (move) begin
						pend_q <= 1'b0;
					end
					if (move && pend_last) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
			endcase
		end
	end

	assign res_valid   = res_v_q;
	assign res_item    = res_q;
	assign st.loading  = (state_q == ST_LOAD);
	assign st.sorting  = (state_q == ST_SORT) || (state_q == ST_PEND);
	assign st.emitting = (state_q == ST_EMIT);

endmodule
